[rtl/kmsc_pkg.sv]
// Keypad matrix scan controller: shared package.
// Holds widths, action codes, register offsets, bit positions and the request
// and response types. No dependencies.
package kmsc_pkg;

  // Matrix geometry
  localparam int ROWS       = 16;
  localparam int COLS       = 16;
  localparam int SCAN_DEPTH = 16;
  localparam int SCAN_W     = 16;

  // Field widths
  localparam int ACTION_W = 3;
  localparam int ADDR_W   = 7;
  localparam int DATA_W   = 32;
  localparam int KEY_W    = 4;
  localparam int IRQ_W    = 3;
  localparam int CNT_W    = 17;
  localparam int RTIME_W  = 14;
  localparam int RCNT_W   = 5;
  localparam int PAIR_W   = 3;

  // Actions
  localparam logic [ACTION_W-1:0] ACT_TICK  = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_READ  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_WRITE = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_KEY   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_TOUCH = 3'd4;

  // Register window offsets
  localparam logic [ADDR_W-1:0] ADDR_CTRL  = 7'h00;
  localparam logic [ADDR_W-1:0] ADDR_SIZE  = 7'h04;
  localparam logic [ADDR_W-1:0] ADDR_IPEND = 7'h08;
  localparam logic [ADDR_W-1:0] ADDR_IMASK = 7'h0C;
  localparam logic [ADDR_W-1:0] ADDR_SCAN0 = 7'h10;
  localparam logic [ADDR_W-1:0] ADDR_SCAN1 = 7'h14;
  localparam logic [ADDR_W-1:0] ADDR_SCAN2 = 7'h18;
  localparam logic [ADDR_W-1:0] ADDR_SCAN3 = 7'h1C;
  localparam logic [ADDR_W-1:0] ADDR_SCAN4 = 7'h20;
  localparam logic [ADDR_W-1:0] ADDR_SCAN5 = 7'h24;
  localparam logic [ADDR_W-1:0] ADDR_SCAN6 = 7'h28;
  localparam logic [ADDR_W-1:0] ADDR_SCAN7 = 7'h2C;
  localparam logic [ADDR_W-1:0] ADDR_RSV0  = 7'h30;
  localparam logic [ADDR_W-1:0] ADDR_RSV1  = 7'h34;
  localparam logic [ADDR_W-1:0] ADDR_RSV2  = 7'h38;
  localparam logic [ADDR_W-1:0] ADDR_RSV3  = 7'h3C;
  localparam logic [ADDR_W-1:0] ADDR_GMASK = 7'h40;
  localparam logic [ADDR_W-1:0] ADDR_GPEND = 7'h44;
  localparam logic [ADDR_W-1:0] ADDR_RSV4  = 7'h48;

  // Scan data words start at this word index of the window
  localparam logic [3:0] SCAN_WORD_BASE = 4'd4;

  // Control register bits
  localparam int CTRL_CONT = 0;
  localparam int CTRL_EN   = 1;

  // Keypad interrupt bits
  localparam logic [IRQ_W-1:0] IRQ_DONE   = 3'b001;
  localparam logic [IRQ_W-1:0] IRQ_CHANGE = 3'b010;

  // GPIO pending bit raised by a touch event
  localparam logic [DATA_W-1:0] GPIO_TOUCH = 32'h0000_0800;

  // Row r clears bit (DIAG_SUM - r) when that bit lies inside the row word
  localparam logic [RCNT_W-1:0] DIAG_SUM = 5'd19;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [ADDR_W-1:0]   addr;
    logic [DATA_W-1:0]   wdata;
    logic [KEY_W-1:0]    key_row;
    logic [KEY_W-1:0]    key_col;
    logic                key_down;
  } kmsc_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] rdata;
    logic              irq;
    logic              bad_access;
  } kmsc_rsp_t;

endpackage

[rtl/kmsc_if.sv]
// Keypad matrix scan controller: request and response channel interfaces.
// Depends on kmsc_pkg for field widths.
interface kmsc_in_if import kmsc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [ADDR_W-1:0]   addr;
  logic [DATA_W-1:0]   wdata;
  logic [KEY_W-1:0]    key_row;
  logic [KEY_W-1:0]    key_col;
  logic                key_down;

  modport source (output valid, action, addr, wdata, key_row, key_col, key_down,
                  input ready);
  modport sink (input valid, action, addr, wdata, key_row, key_col, key_down,
                output ready);
endinterface

interface kmsc_out_if import kmsc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] rdata;
  logic              irq;
  logic              bad_access;

  modport source (output valid, rdata, irq, bad_access, input ready);
  modport sink (input valid, rdata, irq, bad_access, output ready);
endinterface

[rtl/keypad_matrix_scan_controller.sv]
// Keypad matrix scan controller: top level.
// Depends on kmsc_pkg, kmsc_if, kmsc_in_reg, kmsc_core and kmsc_out_reg.
//
//   channel  dir  handshake       payload
//   in_bus   in   valid / ready   action, addr, wdata, key_row, key_col, key_down
//   out_bus  out  valid / ready   rdata, irq, bad_access
//   cfg_*    in   cfg_we          cfg_wdata (invert_rows)
//
// One request per cycle sustained while out_bus.ready stays high; each request is held in the input
// register and then loaded into the result register, which raises out_bus.valid.
// Every request type, including a row scan on timer expiry, completes in the single core pass;
// besides the input, result and configuration registers, the core register file is the only state.
// Synchronous active-low reset clears all state but the request and result payloads; no clearing pass is needed.
// With out_bus.ready low the result holds, one more request is taken into the
// input register, and then in_bus.ready drops until the result is taken.
module keypad_matrix_scan_controller import kmsc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  kmsc_in_if.sink    in_bus,
  kmsc_out_if.source out_bus
);

  logic      invert_r;
  kmsc_req_t in_req;
  kmsc_req_t req;
  logic      req_valid;
  logic      out_can_take;
  logic      step;
  kmsc_rsp_t rsp;
  kmsc_rsp_t out_rsp;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      invert_r <= 1'b0;
    end else if (cfg_we) begin
      invert_r <= cfg_wdata;
    end
  end

  // Gather the request payload
  assign in_req.action   = in_bus.action;
  assign in_req.addr     = in_bus.addr;
  assign in_req.wdata    = in_bus.wdata;
  assign in_req.key_row  = in_bus.key_row;
  assign in_req.key_col  = in_bus.key_col;
  assign in_req.key_down = in_bus.key_down;

  // Advance the held request when the result register has room
  assign step = req_valid && out_can_take;

  kmsc_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_ready  (in_bus.ready),
    .in_req    (in_req),
    .step      (step),
    .req_valid (req_valid),
    .req       (req)
  );

  kmsc_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .req         (req),
    .invert_rows (invert_r),
    .rsp         (rsp)
  );

  kmsc_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step),
    .rsp       (rsp),
    .can_take  (out_can_take),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .out_rsp   (out_rsp)
  );

  assign out_bus.rdata      = out_rsp.rdata;
  assign out_bus.irq        = out_rsp.irq;
  assign out_bus.bad_access = out_rsp.bad_access;

`ifndef NO_ASSERTIONS
  // A processed request always shows up as a result on the next cycle
  a_step_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_bus.valid)
    else $error("processed request did not produce a result");

  // Never overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && !out_bus.ready) |-> !step)
    else $error("result overwritten while stalled");

  // An empty input stage always takes a request
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !req_valid |-> in_bus.ready)
    else $error("input stage empty but not ready");
`endif

endmodule

[rtl/kmsc_in_reg.sv]
// Keypad matrix scan controller: input register stage.
// Captures one request and holds it until the core consumes it. Uses kmsc_pkg.
module kmsc_in_reg import kmsc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  kmsc_req_t in_req,
  input  logic      step,
  output logic      req_valid,
  output kmsc_req_t req
);

  logic      valid_r, valid_nxt;
  kmsc_req_t req_r;
  logic      accept;

  // Take a new request when empty or when the held one leaves this cycle
  assign in_ready = !valid_r || step;
  assign accept   = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (step) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload: load on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req;
    end
  end

  assign req_valid = valid_r;
  assign req       = req_r;

endmodule

[rtl/kmsc_core.sv]
// Keypad matrix scan controller: register file, key matrix, scan timer and
// row former. Updates all state for one request per step. Uses kmsc_pkg.
module kmsc_core import kmsc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  kmsc_req_t req,
  input  logic      invert_rows,
  output kmsc_rsp_t rsp
);

  logic [DATA_W-1:0] ctrl_r, ctrl_nxt;
  logic [DATA_W-1:0] size_r, size_nxt;
  logic [IRQ_W-1:0]  ipend_r, ipend_nxt;
  logic [IRQ_W-1:0]  imask_r, imask_nxt;
  logic [DATA_W-1:0] gmask_r, gmask_nxt;
  logic [DATA_W-1:0] gpend_r, gpend_nxt;
  logic [SCAN_W-1:0] scan_r [SCAN_DEPTH];
  logic [SCAN_W-1:0] scan_nxt [SCAN_DEPTH];
  logic [SCAN_W-1:0] key_r [SCAN_DEPTH];
  logic [SCAN_W-1:0] key_nxt [SCAN_DEPTH];
  logic [3:0]        row_r, row_nxt;
  logic              armed_r, armed_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  logic [RTIME_W-1:0]  rt_cur, rt_wr;
  logic [CNT_W-1:0]    fd_cur, fd_wr, cnt_dec;
  logic [SCAN_W-1:0]   keys, raw_word, word;
  logic [SCAN_DEPTH-1:0] chg_vec;
  logic                chg;
  logic [7:0]          cols;
  logic [RCNT_W-1:0]   row_cnt, row_next;
  logic [PAIR_W-1:0]   pair;
  logic [DATA_W-1:0]   rdata;
  logic                bad;
  logic                irq;

  // Row time (zero counts as one) and initial delay plus row time
  assign rt_cur = (ctrl_r[15:2] == '0) ? RTIME_W'(1) : ctrl_r[15:2];
  assign rt_wr  = (req.wdata[15:2] == '0) ? RTIME_W'(1) : req.wdata[15:2];
  assign fd_cur = CNT_W'(ctrl_r[31:16]) + CNT_W'(rt_cur);
  assign fd_wr  = CNT_W'(req.wdata[31:16]) + CNT_W'(rt_wr);
  assign cnt_dec = (cnt_r != '0) ? cnt_r - CNT_W'(1) : cnt_r;

  // Form the scanned row word for the current row
  assign keys = key_r[row_r];
  assign cols = size_r[15:8];

  always_comb begin
    for (int b = 0; b < SCAN_W; b++) begin
      raw_word[b] = (~keys[b] && ((RCNT_W'(b) + {1'b0, row_r}) != DIAG_SUM)) ||
                    ((cols < 8'(SCAN_W)) && (8'(b) >= cols));
    end
    word = invert_rows ? ~raw_word : raw_word;
  end

  // Each stored row compares itself against the new word
  always_comb begin
    for (int i = 0; i < SCAN_DEPTH; i++) begin
      chg_vec[i] = (scan_r[i] != word);
    end
  end
  assign chg = chg_vec[row_r];

  // Row count saturates at the matrix height
  assign row_cnt  = (size_r[7:0] > 8'(ROWS)) ? RCNT_W'(ROWS) : size_r[RCNT_W-1:0];
  assign row_next = {1'b0, row_r} + RCNT_W'(1);

  // Scan data word index within the window: rows 2*pair and 2*pair+1
  assign pair = PAIR_W'(req.addr[5:2] - SCAN_WORD_BASE);

  // Next-state and response for the request in hand
  always_comb begin
    ctrl_nxt  = ctrl_r;
    size_nxt  = size_r;
    ipend_nxt = ipend_r;
    imask_nxt = imask_r;
    gmask_nxt = gmask_r;
    gpend_nxt = gpend_r;
    scan_nxt  = scan_r;
    key_nxt   = key_r;
    row_nxt   = row_r;
    armed_nxt = armed_r;
    cnt_nxt   = cnt_r;
    rdata     = '0;
    bad       = 1'b0;

    unique case (req.action)
      ACT_TICK: begin
        if (armed_r) begin
          cnt_nxt = cnt_dec;
          if (cnt_dec == '0) begin
            if (chg) begin
              scan_nxt[row_r] = word;
              ipend_nxt       = ipend_nxt | IRQ_CHANGE;
            end
            if (row_next < row_cnt) begin
              row_nxt = row_next[3:0];
              cnt_nxt = CNT_W'(rt_cur);
            end else begin
              row_nxt   = '0;
              ipend_nxt = ipend_nxt | IRQ_DONE;
              if (ctrl_r[CTRL_CONT]) begin
                cnt_nxt = fd_cur;
              end else begin
                ctrl_nxt[CTRL_EN]   = 1'b0;
                ctrl_nxt[CTRL_CONT] = 1'b0;
                armed_nxt           = 1'b0;
                cnt_nxt             = '0;
              end
            end
          end
        end
      end
      ACT_READ: begin
        unique case (req.addr)
          ADDR_CTRL:  rdata = ctrl_r;
          ADDR_SIZE:  rdata = size_r;
          ADDR_IPEND: rdata = DATA_W'(ipend_r);
          ADDR_IMASK: rdata = DATA_W'(imask_r);
          ADDR_SCAN0, ADDR_SCAN1, ADDR_SCAN2, ADDR_SCAN3,
          ADDR_SCAN4, ADDR_SCAN5, ADDR_SCAN6, ADDR_SCAN7: begin
            rdata = {scan_r[{pair, 1'b1}], scan_r[{pair, 1'b0}]};
          end
          ADDR_RSV0, ADDR_RSV1, ADDR_RSV2, ADDR_RSV3, ADDR_RSV4: rdata = '0;
          ADDR_GMASK: rdata = gmask_r;
          ADDR_GPEND: rdata = gpend_r;
          default:    bad = 1'b1;
        endcase
      end
      ACT_WRITE: begin
        unique case (req.addr)
          ADDR_CTRL: begin
            ctrl_nxt = req.wdata;
            if (req.wdata[CTRL_EN]) begin
              cnt_nxt   = fd_wr;
              armed_nxt = 1'b1;
            end else begin
              cnt_nxt   = '0;
              armed_nxt = 1'b0;
            end
          end
          ADDR_SIZE:  size_nxt  = req.wdata;
          ADDR_IPEND: ipend_nxt = ipend_r & ~req.wdata[IRQ_W-1:0];
          ADDR_IMASK: imask_nxt = req.wdata[IRQ_W-1:0];
          ADDR_RSV0, ADDR_RSV1, ADDR_RSV3, ADDR_RSV4: ;
          ADDR_GMASK: gmask_nxt = req.wdata;
          ADDR_GPEND: gpend_nxt = gpend_r & ~req.wdata;
          default:    bad = 1'b1;
        endcase
      end
      ACT_KEY: begin
        if (({1'b0, req.key_row} < RCNT_W'(ROWS)) &&
            ({1'b0, req.key_col} < RCNT_W'(COLS))) begin
          key_nxt[req.key_row][req.key_col] = req.key_down;
        end
      end
      ACT_TOUCH: begin
        gpend_nxt = gpend_r | GPIO_TOUCH;
      end
      default: ;
    endcase
  end

  // Interrupt level after this request's update
  assign irq = (|(imask_nxt & ipend_nxt)) || (|(gmask_nxt & gpend_nxt));

  assign rsp.rdata      = rdata;
  assign rsp.irq        = irq;
  assign rsp.bad_access = bad;

  // Commit state when the request leaves the input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r  <= '0;
      size_r  <= '0;
      ipend_r <= '0;
      imask_r <= '0;
      gmask_r <= '0;
      gpend_r <= '0;
      for (int i = 0; i < SCAN_DEPTH; i++) begin
        scan_r[i] <= '0;
        key_r[i]  <= '0;
      end
      row_r   <= '0;
      armed_r <= 1'b0;
      cnt_r   <= '0;
    end else if (step) begin
      ctrl_r  <= ctrl_nxt;
      size_r  <= size_nxt;
      ipend_r <= ipend_nxt;
      imask_r <= imask_nxt;
      gmask_r <= gmask_nxt;
      gpend_r <= gpend_nxt;
      scan_r  <= scan_nxt;
      key_r   <= key_nxt;
      row_r   <= row_nxt;
      armed_r <= armed_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

[rtl/kmsc_out_reg.sv]
// Keypad matrix scan controller: result register.
// Holds one response until the sink takes it. Uses kmsc_pkg.
module kmsc_out_reg import kmsc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  kmsc_rsp_t rsp,
  output logic      can_take,
  output logic      out_valid,
  input  logic      out_ready,
  output kmsc_rsp_t out_rsp
);

  logic      valid_r, valid_nxt;
  kmsc_rsp_t rsp_r;

  // Room when empty or when the held result is taken this cycle
  assign can_take = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload: load a fresh result
  always_ff @(posedge clk) begin
    if (load) begin
      rsp_r <= rsp;
    end
  end

  assign out_valid = valid_r;
  assign out_rsp   = rsp_r;

endmodule
